FILE: rtl/core/rrc_pkg.sv
`timescale 1ns / 1ps
// Package for the register range coalescer: operation and status codes,
// item and result word types, controller/datapath command and status types.
// No dependencies.
package rrc_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [3:0] ST_NEW      = 4'd0;
    localparam logic [3:0] ST_EXTENDED = 4'd1;
    localparam logic [3:0] ST_MERGED   = 4'd2;
    localparam logic [3:0] ST_COVERED  = 4'd3;
    localparam logic [3:0] ST_FULL     = 4'd4;
    localparam logic [3:0] ST_HIT      = 4'd5;
    localparam logic [3:0] ST_MISS     = 4'd6;
    localparam logic [3:0] ST_LISTED   = 4'd7;
    localparam logic [3:0] ST_NONE     = 4'd8;
    localparam logic [3:0] ST_CLEARED  = 4'd9;

    // Most words one list operation reports.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] REG_MAX   = 16'hFFFF;
    localparam logic [15:0] THRESH_RST = 16'd8;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  slave_id;
        logic [1:0]  data_source;
        logic [15:0] register_number;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic [15:0] offset_in_range;
        logic        is_last;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic compare;
        logic decide;
        logic merge_cmp;
        logic merge;
        logic list_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] operation;
        logic       extend;
        logic       out_free;
        logic       list_last;
    } t_sts;

endpackage

FILE: rtl/core/rrc_req_if.sv
`timescale 1ns / 1ps
// Request channel of the register range coalescer: valid/ready plus item fields.
// No dependencies.
interface rrc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  slave_id;
    logic [1:0]  data_source;
    logic [15:0] register_number;

    modport source (output valid, operation, slave_id, data_source, register_number,
                    input ready);
    modport sink   (input valid, operation, slave_id, data_source, register_number,
                    output ready);
endinterface

FILE: rtl/core/rrc_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the register range coalescer: valid/ready plus result fields.
// No dependencies.
interface rrc_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] range_first;
    logic [15:0] range_last;
    logic [15:0] offset_in_range;
    logic        is_last;

    modport source (output valid, status, range_first, range_last, offset_in_range,
                    is_last, input ready);
    modport sink   (input valid, status, range_first, range_last, offset_in_range,
                    is_last, output ready);
endinterface

FILE: rtl/core/register_range_coalescer.sv
`timescale 1ns / 1ps
// Top level of the register range coalescer: controller plus datapath.
// Depends on rrc_pkg, rrc_req_if, rrc_rsp_if, rrc_ctrl and rrc_datapath.
//
//   Channel   Direction  Handshake           Word
//   i_req     in         valid/ready         operation, slave_id, data_source,
//                                             register_number
//   o_rsp     out        valid/ready         status, range_first, range_last,
//                                             offset_in_range, is_last
//   cfg       in         i_cfg_wr_en only    hit length threshold (16 bits)
//
// Clear, lookup, covered/new/full add: accept, compare, decide. Extending add:
// the same plus a merge compare and a merge write. List: accept, compare, decide,
// then list steps; the compare pass over all slots is registered once and the
// find-first walk emits one word a cycle while the output register is free.
// Reset (i_rst_n low, synchronous) empties the table and sets the threshold to 8.
// A stalled o_rsp holds its word; the next word waits in the datapath until
// the output register frees, while a new request is still taken once idle.
module register_range_coalescer #(
    parameter int RANGE_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    rrc_req_if.sink      i_req,
    rrc_rsp_if.source    o_rsp
);

    rrc_pkg::t_item item;
    rrc_pkg::t_rsp  rsp;
    rrc_pkg::t_cmd  cmd;
    rrc_pkg::t_sts  sts;
    logic           rsp_valid;

    // pack the incoming word
    assign item.operation       = i_req.operation;
    assign item.slave_id        = i_req.slave_id;
    assign item.data_source     = i_req.data_source;
    assign item.register_number = i_req.register_number;

    rrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rrc_datapath #(
        .RANGE_SLOTS (RANGE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (rsp_valid),
        .o_rsp         (rsp)
    );

    // unpack the outgoing word
    assign o_rsp.valid           = rsp_valid;
    assign o_rsp.status          = rsp.status;
    assign o_rsp.range_first     = rsp.range_first;
    assign o_rsp.range_last      = rsp.range_last;
    assign o_rsp.offset_in_range = rsp.offset_in_range;
    assign o_rsp.is_last         = rsp.is_last;

endmodule

FILE: rtl/core/rrc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the register range coalescer: range table, parallel compare
// vectors, merge and list logic, output register. Depends on rrc_pkg.
module rrc_datapath #(
    parameter int RANGE_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  rrc_pkg::t_item      i_item,
    input  rrc_pkg::t_cmd       i_cmd,
    output rrc_pkg::t_sts       o_sts,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output rrc_pkg::t_rsp       o_rsp
);

    localparam int IDX_W = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;

    // range table
    logic [RANGE_SLOTS-1:0] r_valid;
    logic [7:0]             r_slave [RANGE_SLOTS];
    logic [1:0]             r_src   [RANGE_SLOTS];
    logic [15:0]            r_first [RANGE_SLOTS];
    logic [15:0]            r_last  [RANGE_SLOTS];

    logic [15:0]            r_thresh;
    rrc_pkg::t_item         r_item;

    // registered compare vectors
    logic [RANGE_SLOTS-1:0] r_tag, r_cover, r_pre, r_app, r_qual, r_other, r_list;
    logic [RANGE_SLOTS-1:0] c_tag, c_cover, c_pre, c_app, c_qual, c_other;

    logic [IDX_W-1:0]       r_hit;
    logic [15:0]            r_ef, r_el;
    logic [rrc_pkg::CNT_W-1:0] r_list_cnt;

    logic                   r_ov;
    rrc_pkg::t_rsp          r_rsp, n_rsp;
    logic                   rsp_load;

    logic                   any_cover, any_pre, any_app, any_free, any_other, extend;
    logic [IDX_W-1:0]       cover_idx, pre_idx, app_idx, free_idx, other_idx, list_idx;
    logic [RANGE_SLOTS-1:0] list_rest;
    logic                   list_last;
    logic                   out_free;
    logic [15:0]            reg_inc, reg_dec, el_inc, ef_dec;

    function automatic logic [IDX_W-1:0] f_first(input logic [RANGE_SLOTS-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = RANGE_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

    assign reg_inc = r_item.register_number + 16'd1;
    assign reg_dec = r_item.register_number - 16'd1;
    assign el_inc  = r_el + 16'd1;
    assign ef_dec  = r_ef - 16'd1;

    always_comb begin
        for (int i = 0; i < RANGE_SLOTS; i++) begin
            c_tag[i]   = r_valid[i] && (r_slave[i] == r_item.slave_id)
                         && (r_src[i] == r_item.data_source);
            c_cover[i] = c_tag[i] && (r_first[i] <= r_item.register_number)
                         && (r_item.register_number <= r_last[i]);
            c_pre[i]   = c_tag[i] && (r_item.register_number != rrc_pkg::REG_MAX)
                         && (r_first[i] == reg_inc);
            c_app[i]   = c_tag[i] && (r_item.register_number != 16'd0)
                         && (r_last[i] == reg_dec);
            c_qual[i]  = (r_last[i] - r_first[i]) >= r_thresh;
            c_other[i] = (IDX_W'(i) != r_hit) && r_tag[i]
                         && (((r_el != rrc_pkg::REG_MAX) && (r_first[i] == el_inc))
                          || ((r_ef != 16'd0) && (r_last[i] == ef_dec)));
        end
    end

    assign any_cover = |r_cover;
    assign any_pre   = |r_pre;
    assign any_app   = |r_app;
    assign any_free  = ~&r_valid;
    assign any_other = |r_other;
    assign cover_idx = f_first(r_cover);
    assign pre_idx   = f_first(r_pre);
    assign app_idx   = f_first(r_app);
    assign free_idx  = f_first(~r_valid);
    assign other_idx = f_first(r_other);
    assign list_idx  = f_first(r_list);
    assign extend    = (r_item.operation == rrc_pkg::OP_ADD) && !any_cover
                       && (any_pre || any_app);

    always_comb begin
        list_rest = r_list;
        list_rest[list_idx] = 1'b0;
    end
    assign list_last = (r_list == '0) || (list_rest == '0)
                       || (r_list_cnt == rrc_pkg::CNT_W'(rrc_pkg::MAX_RESULTS - 1));

    assign out_free = !r_ov || i_rsp_ready;

    assign o_sts.operation = r_item.operation;
    assign o_sts.extend    = extend;
    assign o_sts.out_free  = out_free;
    assign o_sts.list_last = list_last;

    // result word for the cycle's command
    always_comb begin
        n_rsp    = '0;
        rsp_load = 1'b0;
        n_rsp.is_last = 1'b1;
        if (i_cmd.decide && !extend && (r_item.operation != rrc_pkg::OP_LIST)) begin
            rsp_load = 1'b1;
            unique case (r_item.operation)
                rrc_pkg::OP_CLEAR: n_rsp.status = rrc_pkg::ST_CLEARED;
                rrc_pkg::OP_LOOKUP: begin
                    if (any_cover && r_qual[cover_idx]) begin
                        n_rsp.status          = rrc_pkg::ST_HIT;
                        n_rsp.range_first     = r_first[cover_idx];
                        n_rsp.range_last      = r_last[cover_idx];
                        n_rsp.offset_in_range = r_item.register_number
                                                - r_first[cover_idx];
                    end else begin
                        n_rsp.status = rrc_pkg::ST_MISS;
                    end
                end
                default: begin
                    priority if (any_cover) begin
                        n_rsp.status      = rrc_pkg::ST_COVERED;
                        n_rsp.range_first = r_first[cover_idx];
                        n_rsp.range_last  = r_last[cover_idx];
                    end else if (any_free) begin
                        n_rsp.status      = rrc_pkg::ST_NEW;
                        n_rsp.range_first = r_item.register_number;
                        n_rsp.range_last  = r_item.register_number;
                    end else begin
                        n_rsp.status = rrc_pkg::ST_FULL;
                    end
                end
            endcase
        end else if (i_cmd.merge) begin
            rsp_load = 1'b1;
            if (any_other) begin
                n_rsp.status      = rrc_pkg::ST_MERGED;
                n_rsp.range_first = (r_first[other_idx] < r_ef) ? r_first[other_idx] : r_ef;
                n_rsp.range_last  = (r_last[other_idx] > r_el) ? r_last[other_idx] : r_el;
            end else begin
                n_rsp.status      = rrc_pkg::ST_EXTENDED;
                n_rsp.range_first = r_ef;
                n_rsp.range_last  = r_el;
            end
        end else if (i_cmd.list_step) begin
            rsp_load = 1'b1;
            n_rsp.is_last = list_last;
            if (r_list == '0) begin
                n_rsp.status = rrc_pkg::ST_NONE;
            end else begin
                n_rsp.status      = rrc_pkg::ST_LISTED;
                n_rsp.range_first = r_first[list_idx];
                n_rsp.range_last  = r_last[list_idx];
            end
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_thresh <= rrc_pkg::THRESH_RST;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_thresh <= i_cfg_wr_data;
            if (rsp_load) r_ov <= 1'b1;
            else if (i_rsp_ready) r_ov <= 1'b0;
            if (i_cmd.decide) begin
                if (r_item.operation == rrc_pkg::OP_CLEAR) begin
                    r_valid <= '0;
                end else if ((r_item.operation == rrc_pkg::OP_ADD) && !any_cover
                             && !extend && any_free) begin
                    r_valid[free_idx] <= 1'b1;
                end
            end
            if (i_cmd.merge && any_other) r_valid[other_idx] <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (rsp_load) r_rsp <= n_rsp;
        if (i_cmd.compare) begin
            r_tag      <= c_tag;
            r_cover    <= c_cover;
            r_pre      <= c_pre;
            r_app      <= c_app;
            r_qual     <= c_qual;
            r_list     <= r_valid & c_qual;
            r_list_cnt <= '0;
        end
        if (i_cmd.decide && (r_item.operation == rrc_pkg::OP_ADD) && !any_cover) begin
            if (any_pre) begin
                r_hit              <= pre_idx;
                r_first[pre_idx]   <= r_item.register_number;
                r_ef               <= r_item.register_number;
                r_el               <= r_last[pre_idx];
            end else if (any_app) begin
                r_hit              <= app_idx;
                r_last[app_idx]    <= r_item.register_number;
                r_ef               <= r_first[app_idx];
                r_el               <= r_item.register_number;
            end else if (any_free) begin
                r_slave[free_idx]  <= r_item.slave_id;
                r_src[free_idx]    <= r_item.data_source;
                r_first[free_idx]  <= r_item.register_number;
                r_last[free_idx]   <= r_item.register_number;
            end
        end
        if (i_cmd.merge_cmp) r_other <= c_other;
        if (i_cmd.merge && any_other) begin
            r_first[r_hit] <= n_rsp.range_first;
            r_last[r_hit]  <= n_rsp.range_last;
        end
        if (i_cmd.list_step && (r_list != '0)) begin
            r_list     <= list_rest;
            r_list_cnt <= r_list_cnt + rrc_pkg::CNT_W'(1);
        end
    end

    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_rsp;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && (r_item.operation == rrc_pkg::OP_CLEAR)) |=> (r_valid == '0))
        else $error("table not empty after clear");

    a_merge_frees_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.merge && any_other)
        |=> ($countones(r_valid) + 1 == $past($countones(r_valid))))
        else $error("merge did not free exactly one slot");

    a_new_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && (r_item.operation == rrc_pkg::OP_ADD) && !any_cover
         && !extend && any_free)
        |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("new range did not take exactly one slot");

    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.list_step && (r_list_cnt == rrc_pkg::CNT_W'(rrc_pkg::MAX_RESULTS - 1)))
        |-> n_rsp.is_last)
        else $error("list ran past the result limit");

endmodule

FILE: rtl/core/rrc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the register range coalescer: sequences capture, compare,
// decide, merge and list steps. Depends on rrc_pkg.
module rrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rrc_pkg::t_sts i_sts,
    output rrc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MCMP   = 3'd3;
    localparam logic [2:0] S_MERGE  = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.operation == rrc_pkg::OP_LIST) begin
                    n_state = S_LIST;
                end else if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = i_sts.extend ? S_MCMP : S_IDLE;
                end
            end
            S_MCMP: begin
                o_cmd.merge_cmp = 1'b1;
                n_state         = S_MERGE;
            end
            S_MERGE: begin
                if (i_sts.out_free) begin
                    o_cmd.merge = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.list_step = 1'b1;
                    if (i_sts.list_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: dv/tb_register_range_coalescer.sv
`timescale 1ns / 1ps
// Self-checking testbench for register_range_coalescer: directed table cases, then
// random add/lookup/list/clear traffic under several cache thresholds.
// Depends on rrc_pkg, rrc_req_if, rrc_rsp_if and the register_range_coalescer RTL.
module tb_register_range_coalescer;

    localparam int SLOTS = 16;

    // Shadow copy of one table slot.
    typedef struct {
        logic        occupied;
        logic [7:0]  slave;
        logic [1:0]  src;
        logic [15:0] first;
        logic [15:0] last;
    } t_slot;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;

    rrc_req_if req_ch ();
    rrc_rsp_if rsp_ch ();

    register_range_coalescer #(
        .RANGE_SLOTS(SLOTS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_req        (req_ch),
        .o_rsp        (rsp_ch)
    );

    // Shadow state: slot table and cache threshold as the block should hold them.
    t_slot       shadow_slots[SLOTS];
    logic [15:0] shadow_threshold;

    // Result words still owed by the block, oldest first.
    rrc_pkg::t_rsp expected_words[$];

    bit idle_on;
    int error_count;
    int items_sent;
    int words_checked;
    int thresholds_used;
    int status_seen[16];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the whole run.
    initial begin
        #4_000_000;
        $display("tb_register_range_coalescer: errors");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        if (!idle_on) return 0;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic bit tag_match(input int idx, input logic [7:0] sid,
                                     input logic [1:0] src);
        return shadow_slots[idx].occupied && shadow_slots[idx].slave == sid &&
               shadow_slots[idx].src == src;
    endfunction

    function automatic bit is_cached(input int idx);
        return 16'(shadow_slots[idx].last - shadow_slots[idx].first) >= shadow_threshold;
    endfunction

    // Lowest slot of this tag that holds the register, or -1.
    function automatic int find_cover(input logic [7:0] sid, input logic [1:0] src,
                                      input logic [15:0] reg_n);
        for (int i = 0; i < SLOTS; i++)
            if (tag_match(i, sid, src) && shadow_slots[i].first <= reg_n &&
                reg_n <= shadow_slots[i].last)
                return i;
        return -1;
    endfunction

    function automatic void push_word(input logic [3:0] status, input logic [15:0] first,
                                      input logic [15:0] last, input logic [15:0] ofs,
                                      input logic last_flag);
        rrc_pkg::t_rsp w;
        w.status          = status;
        w.range_first     = first;
        w.range_last      = last;
        w.offset_in_range = ofs;
        w.is_last         = last_flag;
        expected_words.push_back(w);
    endfunction

    // Apply one accepted request to the shadow table and queue the words it owes.
    function automatic void predict_table_op(input rrc_pkg::t_item it);
        int cov;
        int hit;
        int other;
        int listed;
        logic [15:0] r;
        r      = it.register_number;
        hit    = -1;
        other  = -1;
        listed = 0;
        case (it.operation)
            rrc_pkg::OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) shadow_slots[i].occupied = 1'b0;
                push_word(rrc_pkg::ST_CLEARED, 16'd0, 16'd0, 16'd0, 1'b1);
            end
            rrc_pkg::OP_ADD: begin
                cov = find_cover(it.slave_id, it.data_source, r);
                if (cov >= 0) begin
                    push_word(rrc_pkg::ST_COVERED, shadow_slots[cov].first,
                              shadow_slots[cov].last, 16'd0, 1'b1);
                    return;
                end
                // Prepend first, append only if no prepend target exists.
                if (r != rrc_pkg::REG_MAX)
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && tag_match(i, it.slave_id, it.data_source) &&
                            shadow_slots[i].first == 16'(r + 16'd1))
                            hit = i;
                if (hit >= 0) begin
                    shadow_slots[hit].first = r;
                end else if (r != 16'd0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && tag_match(i, it.slave_id, it.data_source) &&
                            shadow_slots[i].last == 16'(r - 16'd1))
                            hit = i;
                    if (hit >= 0) shadow_slots[hit].last = r;
                end
                if (hit >= 0) begin
                    // Fold in at most one same-tag neighbor that now touches.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (other >= 0 || i == hit || !tag_match(i, it.slave_id, it.data_source))
                            continue;
                        if ((shadow_slots[hit].last != rrc_pkg::REG_MAX &&
                             shadow_slots[i].first == 16'(shadow_slots[hit].last + 16'd1)) ||
                            (shadow_slots[hit].first != 16'd0 &&
                             shadow_slots[i].last == 16'(shadow_slots[hit].first - 16'd1)))
                            other = i;
                    end
                    if (other >= 0) begin
                        if (shadow_slots[other].first < shadow_slots[hit].first)
                            shadow_slots[hit].first = shadow_slots[other].first;
                        if (shadow_slots[other].last > shadow_slots[hit].last)
                            shadow_slots[hit].last = shadow_slots[other].last;
                        shadow_slots[other].occupied = 1'b0;
                        push_word(rrc_pkg::ST_MERGED, shadow_slots[hit].first,
                                  shadow_slots[hit].last, 16'd0, 1'b1);
                    end else begin
                        push_word(rrc_pkg::ST_EXTENDED, shadow_slots[hit].first,
                                  shadow_slots[hit].last, 16'd0, 1'b1);
                    end
                    return;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !shadow_slots[i].occupied) hit = i;
                if (hit >= 0) begin
                    shadow_slots[hit].occupied = 1'b1;
                    shadow_slots[hit].slave    = it.slave_id;
                    shadow_slots[hit].src      = it.data_source;
                    shadow_slots[hit].first    = r;
                    shadow_slots[hit].last     = r;
                    push_word(rrc_pkg::ST_NEW, r, r, 16'd0, 1'b1);
                end else begin
                    push_word(rrc_pkg::ST_FULL, 16'd0, 16'd0, 16'd0, 1'b1);
                end
            end
            rrc_pkg::OP_LOOKUP: begin
                cov = find_cover(it.slave_id, it.data_source, r);
                if (cov >= 0 && is_cached(cov))
                    push_word(rrc_pkg::ST_HIT, shadow_slots[cov].first,
                              shadow_slots[cov].last,
                              16'(r - shadow_slots[cov].first), 1'b1);
                else
                    push_word(rrc_pkg::ST_MISS, 16'd0, 16'd0, 16'd0, 1'b1);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++)
                    if (listed < rrc_pkg::MAX_RESULTS && shadow_slots[i].occupied &&
                        is_cached(i)) begin
                        push_word(rrc_pkg::ST_LISTED, shadow_slots[i].first,
                                  shadow_slots[i].last, 16'd0, 1'b0);
                        listed++;
                    end
                if (listed == 0)
                    push_word(rrc_pkg::ST_NONE, 16'd0, 16'd0, 16'd0, 1'b1);
                else
                    expected_words[expected_words.size() - 1].is_last = 1'b1;
            end
        endcase
    endfunction

    // Send one request word. Call at a rising edge; returns at the edge that
    // accepts it, with valid still high so back-to-back words need no drop.
    task automatic send_item(input logic [1:0] op, input logic [7:0] sid,
                             input logic [1:0] src, input logic [15:0] reg_n);
        int gap;
        rrc_pkg::t_item it;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.operation       <= op;
        req_ch.slave_id        <= sid;
        req_ch.data_source     <= src;
        req_ch.register_number <= reg_n;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        it.operation       = op;
        it.slave_id        = sid;
        it.data_source     = src;
        it.register_number = reg_n;
        predict_table_op(it);
        items_sent++;
    endtask

    // Drain every owed word, then give the block time to finish its merge write.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        shadow_threshold = value;
        thresholds_used++;
    endtask

    // Prepend, append, merge, covered and tag separation at the register extremes,
    // all under the reset threshold.
    task automatic test_adjacency();
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd10);     // new
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd10);     // already covered
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd11);     // append
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd9);      // prepend
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd13);     // new
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd0, 16'd12);     // prepend, then merge
        send_item(rrc_pkg::OP_ADD, 8'hFF, 2'd3, 16'd12);     // other tag: new slot
        send_item(rrc_pkg::OP_ADD, 8'hFF, 2'd3, rrc_pkg::REG_MAX); // top: no prepend
        send_item(rrc_pkg::OP_ADD, 8'hFF, 2'd3, 16'hFFFE);   // prepend onto top
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd1, 16'd0);      // bottom register: no append
        send_item(rrc_pkg::OP_ADD, 8'h00, 2'd1, 16'd1);      // append onto bottom
    endtask

    // Lookups and lists below and above the threshold, then with a lowered one.
    task automatic test_cached_lookup();
        send_item(rrc_pkg::OP_LOOKUP, 8'h00, 2'd0, 16'd11);  // too short: miss
        send_item(rrc_pkg::OP_LIST, 8'h00, 2'd0, 16'd0);     // nothing qualifies
        set_threshold(16'd4);
        send_item(rrc_pkg::OP_LOOKUP, 8'h00, 2'd0, 16'd11);  // hit, offset 2
        send_item(rrc_pkg::OP_LOOKUP, 8'h00, 2'd2, 16'd11);  // wrong source: miss
        send_item(rrc_pkg::OP_LIST, 8'h00, 2'd0, 16'd0);
    endtask

    // Fill every free slot, overflow once, then list the whole table.
    task automatic test_full_table();
        for (int i = 0; i < 12; i++)
            send_item(rrc_pkg::OP_ADD, 8'h5A, 2'd2, 16'(100 + 2 * i));
        send_item(rrc_pkg::OP_ADD, 8'h5A, 2'd2, 16'd200);    // no slot left
        set_threshold(16'd0);
        send_item(rrc_pkg::OP_LIST, 8'h00, 2'd0, 16'd0);     // every slot qualifies
        send_item(rrc_pkg::OP_CLEAR, 8'h00, 2'd0, 16'd0);
    endtask

    // Random traffic clustered around one register window so that ranges grow,
    // touch and merge; a few words use random tags or registers as noise.
    task automatic test_random_traffic(input logic [15:0] threshold, input logic [15:0] base,
                                       input bit with_idle, input int count);
        logic [7:0] slaves[2];
        logic [1:0] srcs[2];
        logic [1:0] op;
        logic [7:0] sid;
        logic [1:0] src;
        logic [15:0] reg_n;
        int p;
        int t;
        set_threshold(threshold);
        idle_on = with_idle;
        for (int k = 0; k < 2; k++) begin
            slaves[k] = 8'($urandom);
            srcs[k]   = 2'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(99);
            if (p < 3)       op = rrc_pkg::OP_CLEAR;
            else if (p < 8)  op = rrc_pkg::OP_LIST;
            else if (p < 70) op = rrc_pkg::OP_ADD;
            else             op = rrc_pkg::OP_LOOKUP;
            t = $urandom_range(1);
            if ($urandom_range(9) == 0) begin
                sid = 8'($urandom);
                src = 2'($urandom);
            end else begin
                sid = slaves[t];
                src = srcs[t];
            end
            if ($urandom_range(9) == 0) reg_n = 16'($urandom);
            else                        reg_n = 16'(base + $urandom_range(24));
            send_item(op, sid, src, reg_n);
        end
        idle_on = 1'b1;
    endtask

    // Response ready: stall at random, held high through no-idle phases.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted result word with the oldest one owed.
    initial begin
        rrc_pkg::t_rsp want;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                words_checked++;
                status_seen[rsp_ch.status]++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: status %0d", rsp_ch.status);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.range_first !== want.range_first) begin
                        $error("range_first: expected %0d, got %0d",
                               want.range_first, rsp_ch.range_first);
                        error_count++;
                    end
                    if (rsp_ch.range_last !== want.range_last) begin
                        $error("range_last: expected %0d, got %0d",
                               want.range_last, rsp_ch.range_last);
                        error_count++;
                    end
                    if (rsp_ch.offset_in_range !== want.offset_in_range) begin
                        $error("offset_in_range: expected %0d, got %0d",
                               want.offset_in_range, rsp_ch.offset_in_range);
                        error_count++;
                    end
                    if (rsp_ch.is_last !== want.is_last) begin
                        $error("is_last: expected %0d, got %0d", want.is_last, rsp_ch.is_last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        // Hold every input at a known value, then apply reset.
        rst_n                  <= 1'b0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= 16'd0;
        req_ch.valid           <= 1'b0;
        req_ch.operation       <= rrc_pkg::OP_CLEAR;
        req_ch.slave_id        <= 8'd0;
        req_ch.data_source     <= 2'd0;
        req_ch.register_number <= 16'd0;
        idle_on          = 1'b1;
        shadow_threshold = rrc_pkg::THRESH_RST;
        for (int i = 0; i < SLOTS; i++) shadow_slots[i].occupied = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_adjacency();
        test_cached_lookup();
        test_full_table();
        test_random_traffic(16'd2, 16'($urandom), 1'b1, 40);
        test_random_traffic(16'd0, 16'd0, 1'b0, 40);
        test_random_traffic(16'hFFFF, 16'hFFF0, 1'b1, 40);
        test_random_traffic(16'($urandom_range(6, 1)), 16'($urandom), 1'b1, 40);
        test_random_traffic(16'($urandom_range(12, 3)), 16'($urandom), 1'b1, 40);

        // Drain, then allow for the slowest operation to settle.
        wait_idle();
        $display("covered %0d requests and %0d result words over %0d threshold writes",
                 items_sent, words_checked, thresholds_used);
        $display("merged %0d, full %0d, hit %0d, listed %0d, cleared %0d",
                 status_seen[rrc_pkg::ST_MERGED], status_seen[rrc_pkg::ST_FULL],
                 status_seen[rrc_pkg::ST_HIT], status_seen[rrc_pkg::ST_LISTED],
                 status_seen[rrc_pkg::ST_CLEARED]);
        if (error_count == 0)
            $display("tb_register_range_coalescer: clean");
        else
            $display("tb_register_range_coalescer: errors");
        $finish;
    end

endmodule
